// ===== rtl/core/dsa_signature_generate_defines.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef DSA_SIGNATURE_GENERATE_DEFINES_SVH
`define DSA_SIGNATURE_GENERATE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define DSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define DSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSA_ASSERT_NOW(lbl, ante, cons)
`define DSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/dsa_pkg.sv =====
package dsa_pkg;

  localparam int WORD_BITS = 32;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_PRIME = 2'd0;
  localparam logic [1:0] REG_ORDER = 2'd1;
  localparam logic [1:0] REG_GEN   = 2'd2;
  localparam logic [1:0] REG_KEY   = 2'd3;

  // Arithmetic unit operations; each also names the write-back target.
  localparam logic [3:0] OP_GMODP    = 4'd0;
  localparam logic [3:0] OP_MUL_ACC  = 4'd1;
  localparam logic [3:0] OP_MUL_BASE = 4'd2;
  localparam logic [3:0] OP_RMODQ    = 4'd3;
  localparam logic [3:0] OP_KMODQ    = 4'd4;
  localparam logic [3:0] OP_EUC_DIV  = 4'd5;
  localparam logic [3:0] OP_EUC_MUL  = 4'd6;
  localparam logic [3:0] OP_XMODQ    = 4'd7;
  localparam logic [3:0] OP_XR       = 4'd8;
  localparam logic [3:0] OP_HMODQ    = 4'd9;
  localparam logic [3:0] OP_SIG      = 4'd10;

  typedef struct packed {
    logic [WORD_BITS-1:0] digest;
    logic [WORD_BITS-1:0] nonce;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] sig_r;
    logic [WORD_BITS-1:0] sig_s;
    logic                 nonce_bad;
  } sig_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] prime_modulus;
    logic [WORD_BITS-1:0] group_order;
    logic [WORD_BITS-1:0] generator;
    logic [WORD_BITS-1:0] private_key;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [3:0] op;
    logic       load;
    logic       shift;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic kbit;
    logic cnt_last;
    logic p_zero;
    logic q_zero;
    logic r1_zero;
    logic bad;
    logic unit_done;
  } sts_t;

endpackage

// ===== rtl/core/dsa_mod_unit.sv =====
// Bit-serial arithmetic unit: restoring division (b / m) or modular
// multiplication (a * b mod m, a < m), one bit of b per cycle, MSB first.
module dsa_mod_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           mul_mode,
  input  logic [dsa_pkg::WORD_BITS-1:0]  a,
  input  logic [dsa_pkg::WORD_BITS-1:0]  b,
  input  logic [dsa_pkg::WORD_BITS-1:0]  m,
  output logic                           done,
  output logic [dsa_pkg::WORD_BITS-1:0]  quot,
  output logic [dsa_pkg::WORD_BITS-1:0]  res
);

  localparam int W = dsa_pkg::WORD_BITS;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          mode;
  logic [W-1:0]  sa;
  logic [W-1:0]  sb;
  logic [W-1:0]  sm;
  logic [W-1:0]  acc;
  logic [W-1:0]  qt;

  logic [W+1:0]  mt;
  logic [W+1:0]  mt1;
  logic [W+1:0]  mt2;
  logic [W:0]    dt;
  logic          dge;
  logic [W:0]    dr;
  logic [W-1:0]  acc_next;

  // One step of either operation.
  always_comb begin
    mt  = {1'b0, acc, 1'b0} + {2'b00, (sb[W-1] ? sa : {W{1'b0}})};
    mt1 = (mt >= {2'b00, sm}) ? mt - {2'b00, sm} : mt;
    mt2 = (mt1 >= {2'b00, sm}) ? mt1 - {2'b00, sm} : mt1;
    dt  = {acc, sb[W-1]};
    dge = (dt >= {1'b0, sm});
    dr  = dge ? dt - {1'b0, sm} : dt;
    acc_next = mode ? mt2[W-1:0] : dr[W-1:0];
  end

  // Control of the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (start) begin
      mode <= mul_mode;
      sa   <= a;
      sb   <= b;
      sm   <= m;
      acc  <= '0;
      qt   <= '0;
    end else if (busy) begin
      acc <= acc_next;
      sb  <= {sb[W-2:0], 1'b0};
      qt  <= {qt[W-2:0], dge};
    end
  end

  assign quot = qt;
  assign res  = acc;

endmodule

// ===== rtl/core/dsa_datapath.sv =====
// Working registers of the signature computation around the shared unit.
module dsa_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dsa_pkg::cmd_t       cmd,
  input  dsa_pkg::cfg_t       cfg,
  input  dsa_pkg::item_t      item,
  output dsa_pkg::sts_t       sts,
  output dsa_pkg::sig_t       result
);

  localparam int W = dsa_pkg::WORD_BITS;
  localparam int CW = $clog2(W);

  logic [W-1:0]  hh;
  logic [W-1:0]  kk;
  logic [W-1:0]  ebits;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  base;
  logic [W-1:0]  rres;
  logic [W-1:0]  r0;
  logic [W-1:0]  r1;
  logic [W-1:0]  t0;
  logic [W-1:0]  t1;
  logic [W-1:0]  quo;
  logic [W-1:0]  nr;
  logic [W-1:0]  xm;
  logic [W-1:0]  xr;
  logic [W-1:0]  sum;
  logic [W-1:0]  s;
  logic [3:0]    op_q;

  logic          mul_mode;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic [W-1:0]  um;
  logic          udone;
  logic [W-1:0]  uquot;
  logic [W-1:0]  ures;
  logic [W:0]    nt_wide;
  logic [W:0]    sum_wide;
  logic [W:0]    sum_red;

  // Operand selection for the operation being started.
  always_comb begin
    mul_mode = 1'b0;
    ua = '0;
    ub = '0;
    um = cfg.group_order;
    case (cmd.op)
      dsa_pkg::OP_GMODP: begin
        ub = cfg.generator;
        um = cfg.prime_modulus;
      end
      dsa_pkg::OP_MUL_ACC: begin
        mul_mode = 1'b1;
        ua = acc;
        ub = base;
        um = cfg.prime_modulus;
      end
      dsa_pkg::OP_MUL_BASE: begin
        mul_mode = 1'b1;
        ua = base;
        ub = base;
        um = cfg.prime_modulus;
      end
      dsa_pkg::OP_RMODQ:   ub = acc;
      dsa_pkg::OP_KMODQ:   ub = kk;
      dsa_pkg::OP_EUC_DIV: begin
        ub = r0;
        um = r1;
      end
      dsa_pkg::OP_EUC_MUL: begin
        mul_mode = 1'b1;
        ua = t1;
        ub = quo;
      end
      dsa_pkg::OP_XMODQ:   ub = cfg.private_key;
      dsa_pkg::OP_XR: begin
        mul_mode = 1'b1;
        ua = xm;
        ub = rres;
      end
      dsa_pkg::OP_HMODQ:   ub = hh;
      dsa_pkg::OP_SIG: begin
        mul_mode = 1'b1;
        ua = t0;
        ub = sum;
      end
      default: ub = '0;
    endcase
  end

  dsa_mod_unit u_unit (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .mul_mode (mul_mode),
    .a        (ua),
    .b        (ub),
    .m        (um),
    .done     (udone),
    .quot     (uquot),
    .res      (ures)
  );

  // Modular subtract for the coefficient update and modular add for h + xr.
  always_comb begin
    nt_wide  = (t0 >= ures) ? {1'b0, t0} - {1'b0, ures}
                            : {1'b0, t0} + {1'b0, cfg.group_order} - {1'b0, ures};
    sum_wide = {1'b0, ures} + {1'b0, xr};
    sum_red  = (sum_wide >= {1'b0, cfg.group_order}) ?
               sum_wide - {1'b0, cfg.group_order} : sum_wide;
  end

  // Load, exponent shift and write-back of unit results.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= dsa_pkg::OP_GMODP;
      cnt  <= '0;
    end else begin
      if (cmd.start) begin
        op_q <= cmd.op;
      end
      if (cmd.load) begin
        hh    <= item.digest;
        kk    <= item.nonce;
        ebits <= item.nonce;
        cnt   <= '0;
        acc   <= (cfg.prime_modulus <= W'(1)) ? '0 : W'(1);
        r0    <= cfg.group_order;
        t0    <= '0;
        t1    <= (cfg.group_order == W'(1)) ? '0 : W'(1);
        rres  <= '0;
        s     <= '0;
      end
      if (cmd.shift) begin
        ebits <= {1'b0, ebits[W-1:1]};
        cnt   <= cnt + 1'b1;
      end
      if (udone) begin
        case (op_q)
          dsa_pkg::OP_GMODP:    base <= ures;
          dsa_pkg::OP_MUL_ACC:  acc  <= ures;
          dsa_pkg::OP_MUL_BASE: base <= ures;
          dsa_pkg::OP_RMODQ:    rres <= ures;
          dsa_pkg::OP_KMODQ:    r1   <= ures;
          dsa_pkg::OP_EUC_DIV: begin
            quo <= uquot;
            nr  <= ures;
          end
          dsa_pkg::OP_EUC_MUL: begin
            t0 <= t1;
            t1 <= nt_wide[W-1:0];
            r0 <= r1;
            r1 <= nr;
          end
          dsa_pkg::OP_XMODQ:    xm  <= ures;
          dsa_pkg::OP_XR:       xr  <= ures;
          dsa_pkg::OP_HMODQ:    sum <= sum_red[W-1:0];
          dsa_pkg::OP_SIG:      s   <= ures;
          default:              s   <= s;
        endcase
      end
    end
  end

  // Status back to the controller and the finished signature.
  always_comb begin
    sts.kbit      = ebits[0];
    sts.cnt_last  = (cnt == CW'(W - 1));
    sts.p_zero    = (cfg.prime_modulus == '0);
    sts.q_zero    = (cfg.group_order == '0);
    sts.r1_zero   = (r1 == '0);
    sts.bad       = (r0 != W'(1));
    sts.unit_done = udone;
    result.sig_r     = rres;
    result.sig_s     = s;
    result.nonce_bad = (r0 != W'(1));
  end

endmodule

// ===== rtl/core/dsa_ctrl.sv =====
// Sequencer: exponentiation, Euclid loop, then the s computation.
module dsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  logic          out_free,
  input  dsa_pkg::sts_t sts,
  output logic          item_ready,
  output dsa_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_POW_TOP   = 4'd2;
  localparam logic [3:0] S_POW_BASE  = 4'd3;
  localparam logic [3:0] S_POW_SHIFT = 4'd4;
  localparam logic [3:0] S_RMOD      = 4'd5;
  localparam logic [3:0] S_KMOD      = 4'd6;
  localparam logic [3:0] S_EUC       = 4'd7;
  localparam logic [3:0] S_EUC_MUL   = 4'd8;
  localparam logic [3:0] S_XR        = 4'd9;
  localparam logic [3:0] S_HMOD      = 4'd10;
  localparam logic [3:0] S_SIG       = 4'd11;
  localparam logic [3:0] S_FIN       = 4'd12;
  localparam logic [3:0] S_WAIT      = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] ret;
  logic [3:0] ret_next;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.q_zero) begin
          state_next = S_FIN;
        end else if (sts.p_zero) begin
          state_next = S_RMOD;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = dsa_pkg::OP_GMODP;
          state_next = S_WAIT;
          ret_next   = S_POW_TOP;
        end
      end
      S_POW_TOP: begin
        if (sts.kbit) begin
          cmd.start  = 1'b1;
          cmd.op     = dsa_pkg::OP_MUL_ACC;
          state_next = S_WAIT;
          ret_next   = S_POW_BASE;
        end else begin
          state_next = S_POW_BASE;
        end
      end
      S_POW_BASE: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_MUL_BASE;
        state_next = S_WAIT;
        ret_next   = S_POW_SHIFT;
      end
      S_POW_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = sts.cnt_last ? S_RMOD : S_POW_TOP;
      end
      S_RMOD: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_RMODQ;
        state_next = S_WAIT;
        ret_next   = S_KMOD;
      end
      S_KMOD: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_KMODQ;
        state_next = S_WAIT;
        ret_next   = S_EUC;
      end
      S_EUC: begin
        if (!sts.r1_zero) begin
          cmd.start  = 1'b1;
          cmd.op     = dsa_pkg::OP_EUC_DIV;
          state_next = S_WAIT;
          ret_next   = S_EUC_MUL;
        end else if (sts.bad) begin
          state_next = S_FIN;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = dsa_pkg::OP_XMODQ;
          state_next = S_WAIT;
          ret_next   = S_XR;
        end
      end
      S_EUC_MUL: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_EUC_MUL;
        state_next = S_WAIT;
        ret_next   = S_EUC;
      end
      S_XR: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_XR;
        state_next = S_WAIT;
        ret_next   = S_HMOD;
      end
      S_HMOD: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_HMODQ;
        state_next = S_WAIT;
        ret_next   = S_SIG;
      end
      S_SIG: begin
        cmd.start  = 1'b1;
        cmd.op     = dsa_pkg::OP_SIG;
        state_next = S_WAIT;
        ret_next   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        if (sts.unit_done) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  assign item_ready = (state == S_IDLE);

endmodule

// ===== rtl/core/dsa_signature_generate.sv =====
// DSA signature generator.
// Input channel (item_valid/item_ready/item): one word holds the message
// hash h and the nonce k. Output channel (sig_valid/sig_ready/sig): one word
// holds r, s and the bad-nonce flag. Domain values p, q, g and the key x are
// written through the APB port at byte addresses 0, 4, 8 and 12.
// Every modular step runs on one bit-serial unit that handles one bit per
// cycle. A rejected nonce skips the s computation, a zero p skips the
// exponentiation and a zero q skips every modular step.
// One item is worked on at a time; the next is taken once the result is
// registered. A finished signature sits in an output register.
// If the receiver stalls, the following result waits in the sequencer
// until that register frees up, and the input stays blocked meanwhile.
// Reset loads p=23, q=11, g=2, x=5 and empties both channels.
module dsa_signature_generate (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  dsa_pkg::item_t       item,
  output logic                 sig_valid,
  input  logic                 sig_ready,
  output dsa_pkg::sig_t        sig,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

`include "dsa_signature_generate_defines.svh"

  dsa_pkg::cfg_t cfg;
  dsa_pkg::cmd_t cmd;
  dsa_pkg::sts_t sts;
  dsa_pkg::sig_t result;
  logic          out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prime_modulus <= 32'd23;
      cfg.group_order   <= 32'd11;
      cfg.generator     <= 32'd2;
      cfg.private_key   <= 32'd5;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        dsa_pkg::REG_PRIME: cfg.prime_modulus <= pwdata;
        dsa_pkg::REG_ORDER: cfg.group_order   <= pwdata;
        dsa_pkg::REG_GEN:   cfg.generator     <= pwdata;
        dsa_pkg::REG_KEY:   cfg.private_key   <= pwdata;
        default:            cfg.private_key   <= cfg.private_key;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      dsa_pkg::REG_PRIME: prdata = cfg.prime_modulus;
      dsa_pkg::REG_ORDER: prdata = cfg.group_order;
      dsa_pkg::REG_GEN:   prdata = cfg.generator;
      dsa_pkg::REG_KEY:   prdata = cfg.private_key;
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  dsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .out_free   (out_free),
    .sts        (sts),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  dsa_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item),
    .sts    (sts),
    .result (result)
  );

  // Output word register.
  assign out_free = !sig_valid || sig_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_valid <= 1'b0;
    end else if (cmd.finish) begin
      sig_valid <= 1'b1;
    end else if (sig_ready) begin
      sig_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sig <= result;
    end
  end

  // A word is only taken while the sequencer is idle.
  `DSA_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready)
  // A result never overwrites a word that is still waiting.
  `DSA_ASSERT_NOW(a_no_overwrite, cmd.finish, !(sig_valid && !sig_ready))
  // A flagged nonce always gives a zero s.
  `DSA_ASSERT_NOW(a_bad_zero, sig_valid && sig.nonce_bad, sig.sig_s == 32'd0)

endmodule

// ===== tb/sv/dsa_signature_generate_test.sv =====
`timescale 1ns / 100ps

module dsa_signature_generate_test;

  // Signature predictor and store of pending signatures.
  class sig_scoreboard;
    logic [31:0] p_mod, q_ord, gen, key;
    dsa_pkg::sig_t pending_sigs[$];
    int unsigned errors, signed_cnt, bad_cnt;

    function new();
      p_mod = 32'd23;
      q_ord = 32'd11;
      gen = 32'd2;
      key = 32'd5;
      errors = 0;
      signed_cnt = 0;
      bad_cnt = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        dsa_pkg::REG_PRIME: p_mod = value;
        dsa_pkg::REG_ORDER: q_ord = value;
        dsa_pkg::REG_GEN:   gen = value;
        default:            key = value;
      endcase
    endfunction

    // Square-and-multiply over all 32 exponent bits, products at 64 bits.
    function logic [63:0] exp_mod(logic [63:0] base, logic [31:0] expo, logic [63:0] m);
      logic [63:0] acc;
      if (m == 0) return 64'd0;
      acc = 64'd1 % m;
      base = base % m;
      for (int i = 0; i < 32; i++) begin
        if (expo[i]) acc = (acc * base) % m;
        base = (base * base) % m;
      end
      return acc;
    endfunction

    // Extended Euclid on signed coefficients; returns 0 when no inverse exists.
    function bit inverse_mod(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
      longint r0, r1, t0, t1, quo, nr, nt;
      r0 = longint'(m);
      r1 = longint'(a % m);
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        quo = r0 / r1;
        nr = r0 - quo * r1;
        nt = t0 - quo * t1;
        r0 = r1;
        r1 = nr;
        t0 = t1;
        t1 = nt;
      end
      inv = 64'd0;
      if (r0 != 1) return 1'b0;
      if (t0 < 0) t0 += longint'(m);
      inv = 64'(t0) % m;
      return 1'b1;
    endfunction

    // Work out the signature for an accepted word.
    function void note_item(dsa_pkg::item_t it);
      dsa_pkg::sig_t exp_sig;
      logic [63:0] q, r, kinv, xr, sum;
      q = {32'd0, q_ord};
      exp_sig = '0;
      exp_sig.nonce_bad = 1'b1;
      if (q != 0) begin
        r = exp_mod({32'd0, gen}, it.nonce, {32'd0, p_mod}) % q;
        exp_sig.sig_r = r[31:0];
        if (inverse_mod({32'd0, it.nonce}, q, kinv)) begin
          xr = (({32'd0, key} % q) * r) % q;
          sum = (({32'd0, it.digest} % q) + xr) % q;
          exp_sig.sig_s = 32'((kinv * sum) % q);
          exp_sig.nonce_bad = 1'b0;
        end
      end
      pending_sigs.push_back(exp_sig);
    endfunction

    // Compare one delivered signature with the oldest prediction.
    function void check_sig(dsa_pkg::sig_t got);
      dsa_pkg::sig_t want;
      if (pending_sigs.size() == 0) begin
        $error("signature with none expected: r=%h s=%h bad=%b",
               got.sig_r, got.sig_s, got.nonce_bad);
        errors++;
        return;
      end
      want = pending_sigs.pop_front();
      signed_cnt++;
      if (got.nonce_bad) bad_cnt++;
      if (got.sig_r !== want.sig_r) begin
        $error("sig_r: expected %h, actual %h", want.sig_r, got.sig_r);
        errors++;
      end
      if (got.sig_s !== want.sig_s) begin
        $error("sig_s: expected %h, actual %h", want.sig_s, got.sig_s);
        errors++;
      end
      if (got.nonce_bad !== want.nonce_bad) begin
        $error("nonce_bad: expected %b, actual %b", want.nonce_bad, got.nonce_bad);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_STALL = 3000;

  logic clk, rst;
  logic item_valid, item_ready;
  dsa_pkg::item_t item;
  logic sig_valid, sig_ready;
  dsa_pkg::sig_t sig;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  sig_scoreboard sb;
  bit idle_on;
  bit long_stall_req;
  int unsigned quiet_cycles;
  int unsigned words_sent;

  dsa_signature_generate dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .sig_valid(sig_valid), .sig_ready(sig_ready), .sig(sig),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both channels at the rising edge and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (sig_valid && sig_ready) sb.check_sig(sig);
      if ((sig_valid && sig_ready) || (item_valid && item_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("dsa_signature_generate_test: errors");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    sig_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_stall_req) begin
        sig_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        long_stall_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sig_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        sig_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // One APB write: setup cycle, then access cycle.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_domain(logic [31:0] p, logic [31:0] q, logic [31:0] g,
                             logic [31:0] x);
    reg_write(dsa_pkg::REG_PRIME, p);
    reg_write(dsa_pkg::REG_ORDER, q);
    reg_write(dsa_pkg::REG_GEN, g);
    reg_write(dsa_pkg::REG_KEY, x);
  endtask

  // Offer one word; valid stays high until the block takes it.
  task automatic send_word(logic [31:0] h, logic [31:0] k);
    dsa_pkg::item_t it;
    it.digest = h;
    it.nonce = k;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    words_sent++;
  endtask

  // Let every signature drain before touching the registers.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_sigs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Nonces favor multiples of q and small values so bad nonces turn up.
  function automatic logic [31:0] pick_nonce();
    logic [63:0] mult;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: begin
        mult = 64'(sb.q_ord) * $urandom_range(1, 7);
        return mult[31:0];
      end
      4: return $urandom_range(1, 64);
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] rp, rq;

  initial begin
    sb = new();
    idle_on = 1'b1;
    long_stall_req = 1'b0;
    quiet_cycles = 0;
    words_sent = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset domain values with nonce extremes and shared factors.
    send_word(32'd0, 32'd1);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd7, 32'd0);
    send_word(32'd3, 32'd11);
    send_word(32'd9, 32'd22);
    send_word(32'hAAAA_5555, 32'h5555_AAAA);
    drain();
    // Zero prime modulus and zero group order.
    load_domain(32'd0, 32'd0, 32'd5, 32'd9);
    send_word(32'd4, 32'd3);
    send_word(32'hFFFF_FFFF, 32'd0);
    drain();
    // Modulus one for both.
    load_domain(32'd1, 32'd1, 32'd3, 32'd7);
    send_word(32'd4, 32'd3);
    send_word(32'd5, 32'd0);
    drain();
    // All registers at their top value.
    load_domain(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd0, 32'd1);
    send_word(32'h1234_5678, 32'd5);
    drain();
    // Composite q with smallest sensible domain.
    load_domain(32'd3, 32'd12, 32'd1, 32'd0);
    send_word(32'd8, 32'd6);
    send_word(32'd8, 32'd5);
    send_word(32'd8, 32'd12);
    drain();

    // Random phases, each under a fresh domain setting.
    for (int ph = 0; ph < 9; ph++) begin
      rp = $urandom();
      rq = (ph % 2 == 0) ? 32'($urandom_range(2, 200)) : $urandom();
      case (ph)
        0: load_domain(32'd23, 32'd11, 32'd2, 32'd5);
        1: load_domain(32'd0, rq, pick_word(), pick_word());
        2: load_domain(rp, 32'd1, pick_word(), pick_word());
        3: load_domain(32'hFFFF_FFFB, 32'hFFFF_FFFF, pick_word(), 32'hFFFF_FFFF);
        default: load_domain(rp | 32'd3, rq, pick_word() | 32'd1, pick_word());
      endcase
      if (ph == 8) idle_on = 1'b0;
      if (ph == 2) long_stall_req = 1'b1;
      for (int n = 0; n < 128; n++) begin
        send_word(pick_word(), pick_nonce());
        // In phase 4 the sender waits out every pending signature once, mid-phase.
        if (ph == 4 && n == 60) begin
          @(negedge clk);
          item_valid <= 1'b0;
          while (sb.pending_sigs.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d words; checked %0d signatures, %0d with a rejected nonce.",
             words_sent, sb.signed_cnt, sb.bad_cnt);
    $display("Domains covered zero, one and full-width moduli plus random settings.");
    if (sb.errors == 0 && sb.pending_sigs.size() == 0) begin
      $display("dsa_signature_generate_test: clean");
    end else begin
      $display("dsa_signature_generate_test: errors");
    end
    $finish;
  end

endmodule
